/* rtl/rjb_pkg.sv */
`default_nettype none
package rjb_pkg;

	localparam int BUFFER_DEPTH_DEF = 4;

	localparam int SEQ_W = 16;
	localparam int LEN_W = 11;
	localparam int TS_W = 32;
	localparam int SPT_W = 16;
	localparam int SLOT_OUT_W = 2;
	localparam int HELD_OUT_W = 3;

	localparam logic [LEN_W-1:0] MIN_PACKET_LEN = 11'd12;
	localparam logic [1:0] SILENCE_LIMIT = 2'd1;
	localparam logic [SPT_W-1:0] SPT_RESET = 16'd160;

	// item kinds on the tuser bit
	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// register index (paddr[2])
	localparam logic REG_SAMPLES_PER_TICK = 1'b0;

	typedef struct packed {
		logic evict;   // drop head, shift all entries down by one
		logic insert;  // open a gap at the position and write the new entry
	} store_cmd_t;

	// packet_accepted in bit 0
	typedef struct packed {
		logic input_lost;
		logic [TS_W-1:0] send_timestamp;
		logic [HELD_OUT_W-1:0] entries_held;
		logic [SLOT_OUT_W-1:0] dropped_slot;
		logic [SEQ_W-1:0] dropped_sequence;
		logic dropped_valid;
		logic [SLOT_OUT_W-1:0] store_slot;
		logic packet_accepted;
	} result_t;

endpackage
`default_nettype wire

/* rtl/rjb_store.sv */
`default_nettype none
module rjb_store #(
	parameter int BUFFER_DEPTH = rjb_pkg::BUFFER_DEPTH_DEF
) (
	input wire clk,
	input rjb_pkg::store_cmd_t cmd,
	input wire [$clog2(BUFFER_DEPTH)-1:0] pos,
	input wire [rjb_pkg::SEQ_W-1:0] ins_seq,
	input wire [$clog2(BUFFER_DEPTH)-1:0] ins_slot,
	output logic [rjb_pkg::SEQ_W-1:0] rd_seq,
	output logic [rjb_pkg::SEQ_W-1:0] head_seq,
	output logic [$clog2(BUFFER_DEPTH)-1:0] head_slot
);
	localparam int IDX_W = $clog2(BUFFER_DEPTH);

	logic [rjb_pkg::SEQ_W-1:0] seq_q [BUFFER_DEPTH];
	logic [IDX_W-1:0] slot_q [BUFFER_DEPTH];

	assign rd_seq = seq_q[pos];
	assign head_seq = seq_q[0];
	assign head_slot = slot_q[0];

	for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.evict) begin
				if (g < BUFFER_DEPTH - 1) begin
					seq_q[g] <= seq_q[(g + 1) % BUFFER_DEPTH];
					slot_q[g] <= slot_q[(g + 1) % BUFFER_DEPTH];
				end
			end else if (cmd.insert) begin
				if (IDX_W'(g) == pos) begin
					seq_q[g] <= ins_seq;
					slot_q[g] <= ins_slot;
				end else if (g > 0 && IDX_W'(g) > pos) begin
					seq_q[g] <= seq_q[(g + BUFFER_DEPTH - 1) % BUFFER_DEPTH];
					slot_q[g] <= slot_q[(g + BUFFER_DEPTH - 1) % BUFFER_DEPTH];
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rjb_seq.sv */
`default_nettype none
module rjb_seq #(
	parameter int BUFFER_DEPTH = rjb_pkg::BUFFER_DEPTH_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire item_valid,
	output logic item_ready,
	input wire item_func,
	input wire [rjb_pkg::SEQ_W-1:0] item_seq,
	input wire [rjb_pkg::LEN_W-1:0] item_len,
	input wire [rjb_pkg::SPT_W-1:0] samples_per_tick,
	output rjb_pkg::store_cmd_t cmd,
	output logic [$clog2(BUFFER_DEPTH)-1:0] pos,
	output logic [rjb_pkg::SEQ_W-1:0] ins_seq,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ins_slot,
	input wire [rjb_pkg::SEQ_W-1:0] rd_seq,
	input wire [rjb_pkg::SEQ_W-1:0] head_seq,
	input wire [$clog2(BUFFER_DEPTH)-1:0] head_slot,
	output logic res_valid,
	input wire res_ready,
	output rjb_pkg::result_t res
);
	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_SCAN = 5'b00100,
		S_INSERT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic func_q;
	logic [rjb_pkg::SEQ_W-1:0] seq_q;
	logic [rjb_pkg::LEN_W-1:0] len_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic [IDX_W-1:0] slot_q;
	logic [rjb_pkg::TS_W-1:0] ts_q;
	logic [1:0] silent_q;
	logic acc_q;
	logic lost_q;
	logic drop_valid_q;
	logic [rjb_pkg::SEQ_W-1:0] drop_seq_q;
	logic [IDX_W-1:0] drop_slot_q;

	logic is_packet;
	logic full;
	logic scan_end;
	logic [IDX_W+1:0] slot_ext;
	logic [IDX_W+1:0] drop_slot_ext;
	logic [CNT_W+2:0] count_ext;

	assign is_packet = (func_q == rjb_pkg::FUNC_PACKET) && (len_q >= rjb_pkg::MIN_PACKET_LEN);
	assign full = (count_q == CNT_W'(BUFFER_DEPTH));
	// single sequence comparator, walked over the entries
	assign scan_end = (pos_q == count_q) || (seq_q < rd_seq);

	assign item_ready = (state_q == S_IDLE);
	assign cmd.evict = (state_q == S_EVAL) && is_packet && full;
	assign cmd.insert = (state_q == S_INSERT);
	assign pos = pos_q[IDX_W-1:0];
	assign ins_seq = seq_q;
	assign ins_slot = slot_q;

	assign slot_ext = {2'b00, slot_q};
	assign drop_slot_ext = {2'b00, drop_slot_q};
	assign count_ext = {3'b000, count_q};

	assign res_valid = (state_q == S_DONE);
	always_comb begin
		res.packet_accepted = acc_q;
		res.store_slot = slot_ext[rjb_pkg::SLOT_OUT_W-1:0];
		res.dropped_valid = drop_valid_q;
		res.dropped_sequence = drop_seq_q;
		res.dropped_slot = drop_slot_ext[rjb_pkg::SLOT_OUT_W-1:0];
		res.entries_held = count_ext[rjb_pkg::HELD_OUT_W-1:0];
		res.send_timestamp = ts_q;
		res.input_lost = lost_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ts_q <= '0;
			silent_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (func_q == rjb_pkg::FUNC_TICK) begin
						if (silent_q > rjb_pkg::SILENCE_LIMIT) begin
							silent_q <= 2'd1;
						end else begin
							silent_q <= silent_q + 2'd1;
						end
						ts_q <= ts_q + {{(rjb_pkg::TS_W - rjb_pkg::SPT_W){1'b0}}, samples_per_tick};
						state_q <= S_DONE;
					end else if (is_packet) begin
						if (full) begin
							count_q <= CNT_W'(BUFFER_DEPTH - 1);
						end
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q <= count_q + 1'b1;
					silent_q <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					func_q <= item_func;
					seq_q <= item_seq;
					len_q <= item_len;
					acc_q <= 1'b0;
					lost_q <= 1'b0;
					drop_valid_q <= 1'b0;
					drop_seq_q <= '0;
					drop_slot_q <= '0;
					slot_q <= '0;
				end
			end
			S_EVAL: begin
				pos_q <= '0;
				if (func_q == rjb_pkg::FUNC_TICK) begin
					lost_q <= (silent_q > rjb_pkg::SILENCE_LIMIT);
				end else if (is_packet) begin
					if (full) begin
						drop_valid_q <= 1'b1;
						drop_seq_q <= head_seq;
						drop_slot_q <= head_slot;
						slot_q <= head_slot;
					end else begin
						slot_q <= count_q[IDX_W-1:0];
					end
				end
			end
			S_SCAN: begin
				if (!scan_end) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			S_INSERT: begin
				acc_q <= 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/rtp_jitter_reorder_buffer.sv */
`default_nettype none
// RTP jitter reorder buffer. Holds up to BUFFER_DEPTH packets as storage-slot
// numbers sorted by 16-bit sequence (plain unsigned compare, equal sequences
// go after held ones); a full buffer evicts and reports its lowest entry and
// hands that slot to the new packet. Packets shorter than 12 bytes are ignored.
// A tick (tuser = 1) adds samples_per_tick to the send timestamp and flags
// input loss after two ticks with no accepted packet. Every item gives one
// result beat. One item is processed at a time: a tick or an ignored packet
// passes the evaluate and done states; an accepted packet also passes a scan
// state, where the single sequence comparator walks k held entries (k at most
// BUFFER_DEPTH - 1) to find the insert position, and then an insert state. The
// result sits in an output register, so a new item is taken while it waits.
module rtp_jitter_reorder_buffer #(
	parameter int BUFFER_DEPTH = rjb_pkg::BUFFER_DEPTH_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	output logic s_tready,
	input wire [31:0] s_tdata,    // sequence_req[15:0], packet_length[26:16], zero pad
	input wire s_tuser,           // func
	output logic m_tvalid,
	input wire m_tready,
	output logic [63:0] m_tdata,  // packet_accepted[0], store_slot[2:1],
	                              // dropped_valid[3], dropped_sequence[19:4],
	                              // dropped_slot[21:20], entries_held[24:22],
	                              // send_timestamp[56:25], input_lost[57], zero pad
	input wire psel,
	input wire penable,
	input wire pwrite,
	input wire [2:0] paddr,
	input wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IDX_W = $clog2(BUFFER_DEPTH);

	logic [rjb_pkg::SPT_W-1:0] spt_q;
	logic m_tvalid_q;
	rjb_pkg::result_t res_q;

	rjb_pkg::store_cmd_t cmd;
	logic [IDX_W-1:0] pos;
	logic [rjb_pkg::SEQ_W-1:0] ins_seq;
	logic [IDX_W-1:0] ins_slot;
	logic [rjb_pkg::SEQ_W-1:0] rd_seq;
	logic [rjb_pkg::SEQ_W-1:0] head_seq;
	logic [IDX_W-1:0] head_slot;
	logic res_valid;
	logic res_ready;
	rjb_pkg::result_t res;

	// config port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= rjb_pkg::SPT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == rjb_pkg::REG_SAMPLES_PER_TICK) begin
			spt_q <= pwdata[rjb_pkg::SPT_W-1:0];
		end
	end
	assign prdata = (paddr[2] == rjb_pkg::REG_SAMPLES_PER_TICK)
		? {{(32 - rjb_pkg::SPT_W){1'b0}}, spt_q} : 32'd0;

	rjb_seq #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item_func(s_tuser),
		.item_seq(s_tdata[15:0]),
		.item_len(s_tdata[26:16]),
		.samples_per_tick(spt_q),
		.cmd(cmd),
		.pos(pos),
		.ins_seq(ins_seq),
		.ins_slot(ins_slot),
		.rd_seq(rd_seq),
		.head_seq(head_seq),
		.head_slot(head_slot),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	rjb_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk(clk),
		.cmd(cmd),
		.pos(pos),
		.ins_seq(ins_seq),
		.ins_slot(ins_slot),
		.rd_seq(rd_seq),
		.head_seq(head_seq),
		.head_slot(head_slot)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(64 - $bits(rjb_pkg::result_t)){1'b0}}, res_q};

endmodule
`default_nettype wire
